[src/ogih_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ogih_pkg;

    localparam int ACC_BITS     = 48;
    localparam int MAX_BINS     = 16;
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_BITS     = 10;
    localparam int BIN_BITS     = 4;
    localparam int ADDR_BITS    = COL_BITS + BIN_BITS;
    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STEPS   = 24;
    localparam int DIV_STEPS    = 17;

    typedef struct packed {
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic               frame_start;
    } ogih_in_t;

    typedef struct packed {
        logic [3:0]  bin_index;
        logic [47:0] bin_value;
        logic        last_bin;
    } ogih_out_t;

    typedef enum logic [1:0] {
        CFG_DIRECTED  = 2'd0,
        CFG_BIN_COUNT = 2'd1,
        CFG_MAG_MODE  = 2'd2,
        CFG_WIDTH     = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQR,
        S_ARITH,
        S_WAIT,
        S_ANG,
        S_MUL,
        S_SQ,
        S_DIVGO,
        S_DIV,
        S_WGT,
        S_BRD,
        S_BWR
    } state_t;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] step);
        logic [31:0] v;
        case (step)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // add two accumulator values, clamping at full scale
    function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                    input logic [ACC_BITS-1:0] b);
        logic [ACC_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[src/ogih_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none

module ogih_cordic
    import ogih_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] ax,
    input  wire logic [15:0] ay,
    output logic             done,
    output logic [30:0]      angle
);

    logic               busy_reg, busy_next;
    logic [4:0]         step_reg, step_next;
    logic signed [35:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               spec_reg, spec_next;
    logic [30:0]        spec_val_reg, spec_val_next;
    logic signed [35:0] dx, dy;
    logic signed [33:0] atan_s;

    // one vectoring rotation per cycle
    always_comb
    begin
        dx            = y_reg >>> step_reg;
        dy            = x_reg >>> step_reg;
        atan_s        = signed'({2'b00, atan_turn(step_reg)});
        busy_next     = busy_reg;
        step_next     = step_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        spec_next     = spec_reg;
        spec_val_next = spec_val_reg;
        if (start)
        begin
            x_next        = signed'({4'b0, ax, 16'b0});
            y_next        = signed'({4'b0, ay, 16'b0});
            z_next        = '0;
            step_next     = '0;
            spec_next     = (ay == 16'd0) || (ax == 16'd0);
            spec_val_next = (ay == 16'd0) ? 31'd0 : 31'h40000000;
            busy_next     = !((ay == 16'd0) || (ax == 16'd0));
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_s;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_s;
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            spec_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            spec_reg <= spec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        spec_val_reg <= spec_val_next;
    end

    // clamp to the first quadrant
    always_comb
    begin
        if (spec_reg)
        begin
            angle = spec_val_reg;
        end
        else if (z_reg < 0)
        begin
            angle = 31'd0;
        end
        else if (z_reg > 34'sh040000000)
        begin
            angle = 31'h40000000;
        end
        else
        begin
            angle = z_reg[30:0];
        end
    end

    assign done = !busy_reg;

endmodule

`default_nettype wire

[src/ogih_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module ogih_isqrt
    import ogih_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] val,
    output logic             done,
    output logic [23:0]      root
);

    logic        busy_reg;
    logic [4:0]  j_reg;
    logic [47:0] v_reg, r_reg;
    logic [47:0] bitv;
    logic [48:0] trial;

    // one result bit, from two bits of the radicand, per step
    assign bitv  = 48'd1 << {j_reg, 1'b0};
    assign trial = {1'b0, r_reg} + {1'b0, bitv};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            j_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            j_reg    <= 5'(SQRT_STEPS - 1);
        end
        else if (busy_reg)
        begin
            j_reg <= j_reg - 5'd1;
            if (j_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= val;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_reg <= v_reg - trial[47:0];
                r_reg <= (r_reg >> 1) + bitv;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    assign done = !busy_reg;
    assign root = r_reg[23:0];

endmodule

`default_nettype wire

[src/ogih_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module ogih_div
    import ogih_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] num,
    input  wire logic [33:0] den,
    output logic             done,
    output logic [16:0]      quo
);

    logic        busy_reg;
    logic [4:0]  i_reg;
    logic [47:0] rem_reg;
    logic [33:0] den_reg;
    logic [16:0] q_reg;
    logic [49:0] dsh;
    logic        fits;

    // restoring division, one quotient bit per cycle
    assign dsh  = {16'b0, den_reg} << i_reg;
    assign fits = {2'b0, rem_reg} >= dsh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            i_reg    <= 5'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            i_reg <= i_reg - 5'd1;
            if (i_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh[47:0];
            end
            q_reg <= {q_reg[15:0], fits};
        end
    end

    assign done = !busy_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

[src/oriented_gradient_integral_histogram.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake               Payload
// pix      in   pix_valid / pix_stall   ogih_in_t  (grad_x, grad_y, frame_start)
// bin      out  bin_valid / bin_stall   ogih_out_t (bin_index, bin_value, last_bin)
// cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel at a time: a new pixel is taken only once the previous pixel's bin pass
// is over. The 28-step angle rotation runs alongside the 24-step root (the root alone
// sets the wait when the rotation is skipped), and the 17-step weight division follows.
// The bin pass takes a line-store read and a write per bin.
// Reset clears control, row sums, column count and restores register defaults;
// the line store is not cleared. A stalled result holds the bin pass in place.
module oriented_gradient_integral_histogram
    import ogih_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pix_valid,
    output logic           pix_stall,
    input  wire ogih_in_t  pix,
    output logic           bin_valid,
    input  wire logic      bin_stall,
    output ogih_out_t      bin,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    state_t state_reg, state_next;

    logic        directed_reg, mag_mode_reg;
    logic [4:0]  bin_count_reg;
    logic [10:0] width_reg;
    logic [4:0]  nb;
    logic [10:0] w_eff;

    ogih_in_t    pix_reg;
    logic [31:0] sum_reg;
    logic [15:0] u_reg;
    logic [39:0] mag_reg;
    logic [20:0] p_reg;
    logic [31:0] sqa_reg;
    logic [32:0] sqb_reg;
    logic [3:0]  left_reg, right_reg, k_reg;
    logic [47:0] hl_reg, hr_reg;
    logic [47:0] row_sums_reg [MAX_BINS];
    logic [COL_BITS-1:0] col_reg;
    logic        first_reg;
    logic        out_valid_reg;
    ogih_out_t   out_reg;

    logic [47:0] line_mem [1 << ADDR_BITS];
    logic [47:0] rd_reg;
    logic [ADDR_BITS-1:0] addr;
    logic        mem_we;
    logic [47:0] wr_val;

    logic        cordic_start, sqrt_start, div_start, bin_go;
    logic        cordic_done, sqrt_done, div_done;
    logic [30:0] t_ang;
    logic [23:0] root;
    logic [16:0] wr;
    logic [15:0] ax, ay;
    logic [31:0] ang32;
    logic [15:0] ang16, u_val;
    logic [15:0] a16;
    logic [16:0] b16, wl;
    logic [47:0] hist, rs_new;
    logic [10:0] col_inc;
    logic        last_k;

    // clamp configuration to its working range
    assign nb    = (bin_count_reg < 5'd2) ? 5'd2 :
                   (bin_count_reg > 5'(MAX_BINS)) ? 5'(MAX_BINS) : bin_count_reg;
    assign w_eff = (width_reg == 11'd0) ? 11'd1 :
                   (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directed_reg  <= 1'b1;
            bin_count_reg <= 5'd9;
            mag_mode_reg  <= 1'b0;
            width_reg     <= 11'd640;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DIRECTED:  directed_reg  <= cfg_data[0];
                CFG_BIN_COUNT: bin_count_reg <= cfg_data[4:0];
                CFG_MAG_MODE:  mag_mode_reg  <= cfg_data[0];
                CFG_WIDTH:     width_reg     <= cfg_data;
                default:       directed_reg  <= directed_reg;
            endcase
        end
    end

    // arithmetic units
    assign ax = pix_reg.grad_x[15] ? 16'(-pix_reg.grad_x) : pix_reg.grad_x;
    assign ay = pix_reg.grad_y[15] ? 16'(-pix_reg.grad_y) : pix_reg.grad_y;

    ogih_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .ax    (ax),
        .ay    (ay),
        .done  (cordic_done),
        .angle (t_ang)
    );

    ogih_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .val   ({sum_reg, 16'b0}),
        .done  (sqrt_done),
        .root  (root)
    );

    ogih_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({sqa_reg, 16'b0}),
        .den   ({1'b0, sqb_reg} + {2'b0, sqa_reg}),
        .done  (div_done),
        .quo   (wr)
    );

    // place the angle in its quadrant and fold for undirected mode
    always_comb
    begin
        if (!pix_reg.grad_x[15] && !pix_reg.grad_y[15])
        begin
            ang32 = {1'b0, t_ang};
        end
        else if (pix_reg.grad_x[15] && !pix_reg.grad_y[15])
        begin
            ang32 = 32'h80000000 - {1'b0, t_ang};
        end
        else if (pix_reg.grad_x[15])
        begin
            ang32 = 32'h80000000 + {1'b0, t_ang};
        end
        else
        begin
            ang32 = 32'd0 - {1'b0, t_ang};
        end
    end

    assign ang16 = 16'((ang32 + 32'h00008000) >> 16);
    assign u_val = directed_reg ? (ang16 + 16'h8000) : ({ang16[14:0], 1'b0} + 16'h8000);

    assign a16 = p_reg[15:0];
    assign b16 = 17'h10000 - {1'b0, a16};
    assign wl  = 17'h10000 - wr;

    // bin pass datapath
    assign addr    = {col_reg, k_reg};
    assign hist    = (k_reg == left_reg) ? hl_reg : (k_reg == right_reg) ? hr_reg : 48'd0;
    assign rs_new  = sat_add(row_sums_reg[k_reg], hist);
    assign wr_val  = sat_add(first_reg ? 48'd0 : rd_reg, rs_new);
    assign last_k  = ({1'b0, k_reg} == nb - 5'd1);
    assign col_inc = {1'b0, col_reg} + 11'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (pix_valid) state_next = S_SQR;
            S_SQR:   state_next = S_ARITH;
            S_ARITH: state_next = S_WAIT;
            S_WAIT:  if (cordic_done && sqrt_done) state_next = S_ANG;
            S_ANG:   state_next = S_MUL;
            S_MUL:   state_next = S_SQ;
            S_SQ:    state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_WGT;
            S_WGT:   state_next = S_BRD;
            S_BRD:   state_next = S_BWR;
            S_BWR:   if (bin_go) state_next = last_k ? S_IDLE : S_BRD;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pix_stall    = 1'b1;
        cordic_start = 1'b0;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        bin_go       = 1'b0;
        unique case (state_reg)
            S_IDLE:  pix_stall = 1'b0;
            S_ARITH:
            begin
                cordic_start = 1'b1;
                sqrt_start   = 1'b1;
            end
            S_DIVGO: div_start = 1'b1;
            S_BWR:   bin_go = !out_valid_reg || !bin_stall;
            default: pix_stall = 1'b1;
        endcase
    end

    assign mem_we = bin_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            first_reg     <= 1'b1;
            k_reg         <= '0;
            for (int i = 0; i < MAX_BINS; i++)
            begin
                row_sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // drop a taken result unless a new one replaces it
            if (bin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!bin_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // frame or row start before the pixel
            if (state_reg == S_SQR)
            begin
                if (pix_reg.frame_start)
                begin
                    col_reg   <= '0;
                    first_reg <= 1'b1;
                    for (int i = 0; i < MAX_BINS; i++)
                    begin
                        row_sums_reg[i] <= '0;
                    end
                end
                else if ({1'b0, col_reg} >= w_eff)
                begin
                    col_reg   <= '0;
                    first_reg <= 1'b0;
                    for (int i = 0; i < MAX_BINS; i++)
                    begin
                        row_sums_reg[i] <= '0;
                    end
                end
            end
            if (state_reg == S_WGT)
            begin
                k_reg <= '0;
            end
            // advance the bin pass, closing the row after its last column
            if (bin_go)
            begin
                k_reg <= k_reg + 4'd1;
                if (last_k && (col_inc >= w_eff))
                begin
                    col_reg   <= '0;
                    first_reg <= 1'b0;
                    for (int i = 0; i < MAX_BINS; i++)
                    begin
                        row_sums_reg[i] <= '0;
                    end
                end
                else
                begin
                    row_sums_reg[k_reg] <= rs_new;
                    if (last_k)
                    begin
                        col_reg <= col_inc[COL_BITS-1:0];
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pix_valid)
        begin
            pix_reg <= pix;
        end
        if (state_reg == S_SQR)
        begin
            sum_reg <= 32'(pix_reg.grad_x * pix_reg.grad_x) + 32'(pix_reg.grad_y * pix_reg.grad_y);
        end
        if (state_reg == S_ANG)
        begin
            u_reg   <= u_val;
            mag_reg <= mag_mode_reg ? {sum_reg, 8'b0} : {16'b0, root};
        end
        if (state_reg == S_MUL)
        begin
            p_reg <= {5'b0, u_reg} * {16'b0, nb};
        end
        if (state_reg == S_SQ)
        begin
            sqa_reg   <= {16'b0, a16} * {16'b0, a16};
            sqb_reg   <= {16'b0, b16} * {16'b0, b16};
            left_reg  <= p_reg[19:16];
            right_reg <= ({1'b0, p_reg[19:16]} + 5'd1 == nb) ? 4'd0 : p_reg[19:16] + 4'd1;
        end
        if (state_reg == S_WGT)
        begin
            hl_reg <= 48'(({17'b0, mag_reg} * {40'b0, wl}) >> 16);
            hr_reg <= 48'(({17'b0, mag_reg} * {40'b0, wr}) >> 16);
        end
        if (bin_go)
        begin
            out_reg.bin_index <= k_reg;
            out_reg.bin_value <= wr_val;
            out_reg.last_bin  <= last_k;
        end
    end

    // line store of the previous row's integrals
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[addr] <= wr_val;
        end
        rd_reg <= line_mem[addr];
    end

    assign bin_valid = out_valid_reg;
    assign bin       = out_reg;

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BWR) |-> ({1'b0, k_reg} < nb))
        else $error("bin counter past bin count");

    a_split_bins: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BRD) |-> (left_reg != right_reg))
        else $error("magnitude split onto a single bin");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        bin_go |=> out_valid_reg)
        else $error("result lost after bin step");

    a_last_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (bin_go && last_k) |=> (state_reg == S_IDLE))
        else $error("bin pass did not end on last bin");

endmodule

`default_nettype wire
